/* rtl/slim_fat_sketch_update_query_macros.svh */
// Assertion macros shared by the sketch RTL.
`ifndef SLIM_FAT_SKETCH_UPDATE_QUERY_MACROS_SVH
`define SLIM_FAT_SKETCH_UPDATE_QUERY_MACROS_SVH
`ifndef ASSERT_OFF
`define SFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SFS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// Types and constants of the slim/fat frequency sketch.
// ----------------------------------------------------------------------------
package sfs_pkg;
	localparam int HASH_INPUTS = 4;
	localparam int HASH_BITS   = 32;
	localparam int DELTA_BITS  = 32;
	localparam int EST_BITS    = 32;
	localparam int COUNTER_BITS = 32;
	localparam int RAW_ROWS_BITS = 3;
	localparam int RAW_SCOL_BITS = 11;
	localparam int RAW_FCOL_BITS = 13;
	localparam int REG_ADDR_BITS = 4;

	localparam logic [REG_ADDR_BITS-1:0] ADDR_ACTIVE_ROWS  = 4'h0;
	localparam logic [REG_ADDR_BITS-1:0] ADDR_SLIM_COLUMNS = 4'h4;
	localparam logic [REG_ADDR_BITS-1:0] ADDR_FAT_COLUMNS  = 4'h8;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_MOD    = 8'b0000_0100,
		ST_READ   = 8'b0000_1000,
		ST_MIN    = 8'b0001_0000,
		ST_FMIN   = 8'b0010_0000,
		ST_WRITE  = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] modulus;
	} mod_ctl_t;
endpackage

/* rtl/sfs_if.sv */
// ----------------------------------------------------------------------------
// sfs_in_if / sfs_out_if
// Valid/ready channels of the sketch.
// ----------------------------------------------------------------------------
interface sfs_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] delta;
	logic [31:0] slim_hash_0;
	logic [31:0] slim_hash_1;
	logic [31:0] slim_hash_2;
	logic [31:0] slim_hash_3;
	logic [31:0] fat_hash_0;
	logic [31:0] fat_hash_1;
	logic [31:0] fat_hash_2;
	logic [31:0] fat_hash_3;
	modport source (output valid, func, delta, slim_hash_0, slim_hash_1, slim_hash_2,
		slim_hash_3, fat_hash_0, fat_hash_1, fat_hash_2, fat_hash_3, input ready);
	modport sink (input valid, func, delta, slim_hash_0, slim_hash_1, slim_hash_2,
		slim_hash_3, fat_hash_0, fat_hash_1, fat_hash_2, fat_hash_3, output ready);
endinterface

interface sfs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] estimate;
	modport source (output valid, estimate, input ready);
	modport sink (input valid, estimate, output ready);
endinterface

/* rtl/slim_fat_sketch_update_query.sv */
// ----------------------------------------------------------------------------
// slim_fat_sketch_update_query
// Slim/fat frequency sketch with insert and query transactions.
// ----------------------------------------------------------------------------
// Each row is a lane with its own slim and fat memories, so all rows are read
// and written in parallel. An insert runs from its acceptance through the
// bit-serial remainder of the hashes by the column counts (start, one step per
// hash bit, done), then a read, a minimum stage, a fat minimum stage and a
// write, before the next acceptance. A query takes the same remainder, a read,
// a minimum stage and a load of the output register; the load waits only
// while the previous estimate has not been taken. After reset a clearing pass
// over the larger of SLIM_DEPTH and FAT_DEPTH addresses zeroes both memories
// before the first transaction.
`include "slim_fat_sketch_update_query_macros.svh"
module slim_fat_sketch_update_query
	import sfs_pkg::*;
#(
	parameter int ROWS         = 4,
	parameter int SLIM_DEPTH   = 1024,
	parameter int FAT_DEPTH    = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	sfs_in_if.sink                   in_ch,
	sfs_out_if.source                out_ch,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [REG_ADDR_BITS-1:0] paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);
	localparam int CLR_DEPTH = (SLIM_DEPTH > FAT_DEPTH) ? SLIM_DEPTH : FAT_DEPTH;
	localparam int CB    = $clog2(CLR_DEPTH);
	localparam int LANES = (ROWS < HASH_INPUTS) ? ROWS : HASH_INPUTS;
	localparam logic [COUNTER_BITS-1:0] CMAX = '1;

	logic [RAW_ROWS_BITS-1:0] rows_q;
	logic [RAW_SCOL_BITS-1:0] scol_q;
	logic [RAW_FCOL_BITS-1:0] fcol_q;
	state_t                   state_q;
	logic [CB-1:0]            clr_q;
	logic                     func_q;
	logic [DELTA_BITS-1:0]    delta_q;
	logic [HASH_BITS-1:0]     sh_q [HASH_INPUTS];
	logic [HASH_BITS-1:0]     fh_q [HASH_INPUTS];
	logic [COUNTER_BITS-1:0]  srd [LANES];
	logic [COUNTER_BITS-1:0]  frd [LANES];
	logic [COUNTER_BITS-1:0]  fnew_q [LANES];
	logic [COUNTER_BITS-1:0]  smin_q;
	logic [COUNTER_BITS-1:0]  fmin_q;
	logic [COUNTER_BITS-1:0]  smin_c;
	logic [COUNTER_BITS-1:0]  fmin_c;
	logic [COUNTER_BITS-1:0]  target;
	logic [COUNTER_BITS:0]    ssum;
	logic [LANES-1:0]         ldone;
	logic [2:0]               rows_use;
	logic [31:0]              smod;
	logic [31:0]              fmod;
	logic                     start_q;
	logic                     out_valid_q;
	logic                     out_load;
	logic [EST_BITS-1:0]      est_q;
	logic                     wr;
	logic [COUNTER_BITS:0]    fsum [LANES];

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 3'd4;
			scol_q <= 11'd1024;
			fcol_q <= 13'd4096;
		end else if (wr) begin
			unique case (paddr)
				ADDR_ACTIVE_ROWS:  rows_q <= pwdata[RAW_ROWS_BITS-1:0];
				ADDR_SLIM_COLUMNS: scol_q <= pwdata[RAW_SCOL_BITS-1:0];
				ADDR_FAT_COLUMNS:  fcol_q <= pwdata[RAW_FCOL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_ACTIVE_ROWS:  prdata = 32'(rows_q);
			ADDR_SLIM_COLUMNS: prdata = 32'(scol_q);
			ADDR_FAT_COLUMNS:  prdata = 32'(fcol_q);
			default:           prdata = '0;
		endcase
	end

	always_comb begin
		if (rows_q == 3'd0) begin
			rows_use = 3'd1;
		end else if (32'(rows_q) > LANES) begin
			rows_use = 3'(LANES);
		end else begin
			rows_use = rows_q;
		end
		if (scol_q == '0) begin
			smod = 32'd1;
		end else if (32'(scol_q) > SLIM_DEPTH) begin
			smod = 32'(SLIM_DEPTH);
		end else begin
			smod = 32'(scol_q);
		end
		if (fcol_q == '0) begin
			fmod = 32'd1;
		end else if (32'(fcol_q) > FAT_DEPTH) begin
			fmod = 32'(FAT_DEPTH);
		end else begin
			fmod = 32'(fcol_q);
		end
	end

	always_comb begin
		smin_c = CMAX;
		fmin_c = CMAX;
		ssum   = '0;
		for (int r = 0; r < LANES; r++) begin
			if (3'(r) < rows_use && srd[r] < smin_c) smin_c = srd[r];
			if (3'(r) < rows_use && fnew_q[r] < fmin_c) fmin_c = fnew_q[r];
		end
		ssum   = {1'b0, smin_q} + (COUNTER_BITS+1)'(delta_q);
		target = (ssum >= {1'b0, fmin_q}) ? fmin_q : ssum[COUNTER_BITS-1:0];
	end

	for (genvar r = 0; r < LANES; r++) begin : g_lane
		mod_ctl_t lsctl;
		mod_ctl_t lfctl;
		assign lsctl = '{start: start_q, modulus: smod};
		assign lfctl = '{start: start_q, modulus: fmod};
		assign fsum[r] = {1'b0, frd[r]} + (COUNTER_BITS+1)'(delta_q);
		sfs_lane #(
			.SLIM_DEPTH(SLIM_DEPTH), .FAT_DEPTH(FAT_DEPTH), .CLR_BITS(CB)
		) u_lane (
			.clk(clk), .arst_n(arst_n), .slim_ctl(lsctl), .fat_ctl(lfctl),
			.slim_hash(sh_q[r]), .fat_hash(fh_q[r]),
			.clear(state_q == ST_CLEAR), .clear_addr(clr_q),
			.slim_we(state_q == ST_WRITE && !func_q && smin_q < fmin_q
				&& 3'(r) < rows_use && srd[r] < target),
			.slim_wdata(target),
			.fat_we(state_q == ST_FMIN && !func_q && 3'(r) < rows_use),
			.fat_wdata(fnew_q[r]),
			.idx_done(ldone[r]), .slim_rdata(srd[r]), .fat_rdata(frd[r])
		);
		always_ff @(posedge clk) begin
			if (state_q == ST_MIN) begin
				fnew_q[r] <= fsum[r][COUNTER_BITS] ? CMAX : fsum[r][COUNTER_BITS-1:0];
			end
		end
	end

	assign out_load        = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);
	assign in_ch.ready     = (state_q == ST_IDLE);
	assign out_ch.valid    = out_valid_q;
	assign out_ch.estimate = est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CB'(CLR_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						start_q <= 1'b1;
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (!start_q && &ldone) begin
						state_q <= ST_READ;
					end
				end
				ST_READ:  state_q <= ST_MIN;
				ST_MIN:   state_q <= func_q ? ST_OUT : ST_FMIN;
				ST_FMIN:  state_q <= ST_WRITE;
				ST_WRITE: state_q <= ST_IDLE;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready) begin
			func_q  <= in_ch.func;
			delta_q <= in_ch.delta;
			sh_q[0] <= in_ch.slim_hash_0;
			sh_q[1] <= in_ch.slim_hash_1;
			sh_q[2] <= in_ch.slim_hash_2;
			sh_q[3] <= in_ch.slim_hash_3;
			fh_q[0] <= in_ch.fat_hash_0;
			fh_q[1] <= in_ch.fat_hash_1;
			fh_q[2] <= in_ch.fat_hash_2;
			fh_q[3] <= in_ch.fat_hash_3;
		end
		if (state_q == ST_MIN) begin
			smin_q <= smin_c;
		end
		if (state_q == ST_FMIN) begin
			fmin_q <= fmin_c;
		end
		if (out_load) begin
			est_q <= smin_q[EST_BITS-1:0];
		end
	end

	`SFS_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`SFS_ASSERT_NEXT(a_accept_mod, clk, arst_n, in_ch.valid && in_ch.ready, state_q == ST_MOD)
	`SFS_ASSERT_NEXT(a_hold_out, clk, arst_n, out_valid_q && !out_ch.ready, out_valid_q && $stable(est_q))
	`SFS_ASSERT_NEXT(a_out_query, clk, arst_n, state_q == ST_OUT, out_valid_q && func_q)
endmodule

/* rtl/sfs_ram.sv */
// ----------------------------------------------------------------------------
// sfs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* rtl/sfs_mod.sv */
// ----------------------------------------------------------------------------
// sfs_mod
// Bit-serial remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfs_mod
	import sfs_pkg::*;
#(
	parameter int IDX_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mod_ctl_t            ctl,
	input  logic [HASH_BITS-1:0] dividend,
	output logic                done,
	output logic [IDX_BITS-1:0] remainder
);
	logic [HASH_BITS-1:0] num_q;
	logic [HASH_BITS:0]   rem_q;
	logic [5:0]           cnt_q;
	logic                 busy_q;
	logic [HASH_BITS:0]   shifted;
	logic [HASH_BITS:0]   modx;

	assign modx    = {1'b0, ctl.modulus};
	assign shifted = {rem_q[HASH_BITS-1:0], num_q[HASH_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(HASH_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[HASH_BITS-2:0], 1'b0};
			rem_q <= (shifted >= modx) ? shifted - modx : shifted;
		end
	end

	assign done      = busy_q && (cnt_q == 6'd1) ? 1'b0 : (!busy_q && !ctl.start);
	assign remainder = rem_q[IDX_BITS-1:0];
endmodule

/* rtl/sfs_lane.sv */
// ----------------------------------------------------------------------------
// sfs_lane
// One row of the sketch: slim and fat counter memories with their indexes.
// ----------------------------------------------------------------------------
module sfs_lane
	import sfs_pkg::*;
#(
	parameter int SLIM_DEPTH   = 1024,
	parameter int FAT_DEPTH    = 4096,
	parameter int CLR_BITS     = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mod_ctl_t                      slim_ctl,
	input  mod_ctl_t                      fat_ctl,
	input  logic [HASH_BITS-1:0]          slim_hash,
	input  logic [HASH_BITS-1:0]          fat_hash,
	input  logic                          clear,
	input  logic [CLR_BITS-1:0]           clear_addr,
	input  logic                          slim_we,
	input  logic [COUNTER_BITS-1:0]       slim_wdata,
	input  logic                          fat_we,
	input  logic [COUNTER_BITS-1:0]       fat_wdata,
	output logic                          idx_done,
	output logic [COUNTER_BITS-1:0]       slim_rdata,
	output logic [COUNTER_BITS-1:0]       fat_rdata
);
	localparam int SB = $clog2(SLIM_DEPTH);
	localparam int FB = $clog2(FAT_DEPTH);

	logic [SB-1:0] sidx;
	logic [FB-1:0] fidx;
	logic          sdone;
	logic          fdone;
	logic [SB-1:0] saddr;
	logic [FB-1:0] faddr;

	sfs_mod #(.IDX_BITS(SB)) u_smod (
		.clk(clk), .arst_n(arst_n), .ctl(slim_ctl), .dividend(slim_hash),
		.done(sdone), .remainder(sidx)
	);
	sfs_mod #(.IDX_BITS(FB)) u_fmod (
		.clk(clk), .arst_n(arst_n), .ctl(fat_ctl), .dividend(fat_hash),
		.done(fdone), .remainder(fidx)
	);

	assign idx_done = sdone && fdone;
	assign saddr    = clear ? clear_addr[SB-1:0] : sidx;
	assign faddr    = clear ? clear_addr[FB-1:0] : fidx;

	sfs_ram #(.WIDTH(COUNTER_BITS), .DEPTH(SLIM_DEPTH)) u_slim (
		.clk(clk), .we(slim_we || clear), .addr(saddr),
		.wdata(clear ? '0 : slim_wdata), .rdata(slim_rdata)
	);
	sfs_ram #(.WIDTH(COUNTER_BITS), .DEPTH(FAT_DEPTH)) u_fat (
		.clk(clk), .we(fat_we || clear), .addr(faddr),
		.wdata(clear ? '0 : fat_wdata), .rdata(fat_rdata)
	);
endmodule
